// File: hw/rtl/e2e_profile1_receive_check_macros.svh
// ----------------------------------------------------------------------------
// e2e_profile1_receive_check_macros
// assertion helpers for the receive check
// ----------------------------------------------------------------------------
`ifndef E2E_PROFILE1_RECEIVE_CHECK_MACROS_SVH
`define E2E_PROFILE1_RECEIVE_CHECK_MACROS_SVH

// checked only out of reset
`define E2ERC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge
`define E2ERC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/e2erc_pkg.sv
// ----------------------------------------------------------------------------
// e2erc_pkg
// types, codes and the crc-8 step of the end-to-end receive check
// ----------------------------------------------------------------------------
package e2erc_pkg;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_REPEATED    = 3'd1,
    ST_WRONG_SEQ   = 3'd2,
    ST_SOME_LOST   = 3'd3,
    ST_WRONG_CRC   = 3'd4,
    ST_NO_NEW_DATA = 3'd5,
    ST_INITIAL     = 3'd6
  } status_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_ID        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_MODE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_OFFSET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BITS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_INIT     = 3'd5;

  localparam logic [1:0] MODE_BOTH = 2'd0;
  localparam logic [1:0] MODE_ALT  = 2'd1;
  localparam logic [1:0] MODE_LOW  = 2'd2;

  localparam logic [7:0] CRC_POLY = 8'h1D;
  localparam logic [3:0] DELTA_SAT = 4'd14;
  localparam logic [4:0] CNT_MOD = 5'd15;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/e2e_profile1_receive_check.sv
// ----------------------------------------------------------------------------
// e2e_profile1_receive_check: input transfer and result are each registered
// 1 byte per cycle when not stalled; crc step, capture and sequence check in one pass
// reset is synchronous: config to defaults, frame position cleared, first frame awaited
// ----------------------------------------------------------------------------
module e2e_profile1_receive_check #(
  parameter int MAX_FRAME_BYTES = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_req_type,
  input  logic [7:0]                          in_data_byte,
  input  logic                                in_last_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_check_status,
  output logic [3:0]                          out_lost_count,
  output logic [3:0]                          out_received_counter,
  input  logic                                cfg_write_en,
  input  logic [e2erc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [e2erc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import e2erc_pkg::*;
  `include "e2e_profile1_receive_check_macros.svh"

  localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_FRAME_BYTES);

  // configuration
  logic [15:0] data_id_r;
  logic [1:0]  id_mode_r;
  logic [7:0]  cnt_off_r;
  logic [7:0]  crc_off_r;
  logic [8:0]  frame_bits_r;
  logic [3:0]  delta_init_r;

  // input register
  logic       s1_valid_r;
  logic       s1_req_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // check state
  logic [7:0]       crc_lo_r, crc_lo_nxt;
  logic [7:0]       crc_hi_r, crc_hi_nxt;
  logic [IDX_W-1:0] byte_idx_r, byte_idx_nxt;
  logic [3:0]       seen_cnt_r, seen_cnt_nxt;
  logic [7:0]       seen_crc_r, seen_crc_nxt;
  logic [3:0]       good_cnt_r, good_cnt_nxt;
  logic [3:0]       delta_limit_r, delta_limit_nxt;
  logic             awaiting_first_r, awaiting_first_nxt;
  logic [3:0]       lost_hold_r, lost_hold_nxt;

  logic       out_valid_r;
  logic [2:0] out_status_r;
  logic [3:0] out_lost_r;
  logic [3:0] out_cnt_r;

  logic       proc_go;
  logic       has_result;
  logic [2:0] status_nxt;
  logic [3:0] res_cnt_nxt;

  logic [7:0] id_lo_crc;
  logic [7:0] lo_start;
  logic [7:0] hi_start;
  logic [3:0] cnt_base;
  logic [7:0] crc_base;
  logic [8:0] idx_ext;
  logic [3:0] dl_aged;
  logic [7:0] calc;
  logic [4:0] diff0, diff1, diff2;
  logic [3:0] delta;

  assign proc_go    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall   = s1_valid_r && !proc_go;
  assign has_result = s1_req_r || s1_last_r;

  always_comb begin
    id_lo_crc = crc8_byte(8'h00, data_id_r[7:0]);
    if (byte_idx_r == '0) begin
      unique case (id_mode_r)
        MODE_BOTH: begin
          lo_start = crc8_byte(id_lo_crc, data_id_r[15:8]);
          hi_start = lo_start;
        end
        MODE_ALT: begin
          lo_start = id_lo_crc;
          hi_start = crc8_byte(8'h00, data_id_r[15:8]);
        end
        default: begin
          lo_start = id_lo_crc;
          hi_start = id_lo_crc;
        end
      endcase
      cnt_base = '0;
      crc_base = '0;
    end else begin
      lo_start = crc_lo_r;
      hi_start = crc_hi_r;
      cnt_base = seen_cnt_r;
      crc_base = seen_crc_r;
    end

    idx_ext      = 9'(byte_idx_r);
    crc_lo_nxt   = lo_start;
    crc_hi_nxt   = hi_start;
    seen_cnt_nxt = cnt_base;
    seen_crc_nxt = crc_base;
    if (byte_idx_r < IDX_MAX) begin
      if (idx_ext == 9'(cnt_off_r[7:3])) begin
        seen_cnt_nxt = (cnt_off_r[2:0] != 3'd0) ? s1_byte_r[7:4] : s1_byte_r[3:0];
      end
      if (idx_ext == 9'(crc_off_r[7:3])) begin
        seen_crc_nxt = s1_byte_r;
      end else if (idx_ext < 9'(frame_bits_r[8:3])) begin
        crc_lo_nxt = crc8_byte(lo_start, s1_byte_r);
        crc_hi_nxt = crc8_byte(hi_start, s1_byte_r);
      end
    end

    dl_aged = (delta_limit_r >= 4'd13) ? DELTA_SAT : delta_limit_r + 4'd1;
    calc    = (id_mode_r == MODE_ALT && seen_cnt_nxt[0]) ? crc_hi_nxt : crc_lo_nxt;

    // counter difference modulo 15
    diff0 = CNT_MOD + 5'(seen_cnt_nxt) - 5'(good_cnt_r);
    diff1 = (diff0 >= CNT_MOD) ? diff0 - CNT_MOD : diff0;
    diff2 = (diff1 >= CNT_MOD) ? diff1 - CNT_MOD : diff1;
    delta = diff2[3:0];

    byte_idx_nxt       = byte_idx_r;
    good_cnt_nxt       = good_cnt_r;
    delta_limit_nxt    = delta_limit_r;
    awaiting_first_nxt = awaiting_first_r;
    lost_hold_nxt      = lost_hold_r;
    status_nxt         = ST_NO_NEW_DATA;
    res_cnt_nxt        = '0;

    if (s1_req_r) begin
      crc_lo_nxt      = crc_lo_r;
      crc_hi_nxt      = crc_hi_r;
      seen_cnt_nxt    = seen_cnt_r;
      seen_crc_nxt    = seen_crc_r;
      delta_limit_nxt = dl_aged;
    end else if (!s1_last_r) begin
      if (byte_idx_r < IDX_MAX) begin
        byte_idx_nxt = byte_idx_r + 1'b1;
      end
    end else begin
      byte_idx_nxt    = '0;
      delta_limit_nxt = dl_aged;
      res_cnt_nxt     = seen_cnt_nxt;
      if (calc != seen_crc_nxt) begin
        status_nxt = ST_WRONG_CRC;
      end else if (awaiting_first_r) begin
        awaiting_first_nxt = 1'b0;
        delta_limit_nxt    = delta_init_r;
        good_cnt_nxt       = seen_cnt_nxt;
        status_nxt         = ST_INITIAL;
      end else if (delta == 4'd0) begin
        status_nxt = ST_REPEATED;
      end else if (delta > dl_aged) begin
        status_nxt = ST_WRONG_SEQ;
      end else begin
        delta_limit_nxt = delta_init_r;
        good_cnt_nxt    = seen_cnt_nxt;
        lost_hold_nxt   = delta - 4'd1;
        status_nxt      = (delta == 4'd1) ? ST_OK : ST_SOME_LOST;
      end
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_id_r        <= '0;
      id_mode_r        <= '0;
      cnt_off_r        <= 8'd8;
      crc_off_r        <= '0;
      frame_bits_r     <= 9'd64;
      delta_init_r     <= 4'd1;
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      crc_lo_r         <= '0;
      crc_hi_r         <= '0;
      byte_idx_r       <= '0;
      seen_cnt_r       <= '0;
      seen_crc_r       <= '0;
      good_cnt_r       <= '0;
      delta_limit_r    <= '0;
      awaiting_first_r <= 1'b1;
      lost_hold_r      <= '0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          CFG_DATA_ID:        data_id_r    <= cfg_wdata;
          CFG_ID_MODE:        id_mode_r    <= cfg_wdata[1:0];
          CFG_COUNTER_OFFSET: cnt_off_r    <= cfg_wdata[7:0];
          CFG_CRC_OFFSET:     crc_off_r    <= cfg_wdata[7:0];
          CFG_FRAME_BITS:     frame_bits_r <= cfg_wdata[8:0];
          CFG_DELTA_INIT:     delta_init_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (proc_go) begin
        s1_valid_r <= 1'b0;
      end
      if (proc_go && has_result) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (proc_go) begin
        crc_lo_r         <= crc_lo_nxt;
        crc_hi_r         <= crc_hi_nxt;
        byte_idx_r       <= byte_idx_nxt;
        seen_cnt_r       <= seen_cnt_nxt;
        seen_crc_r       <= seen_crc_nxt;
        good_cnt_r       <= good_cnt_nxt;
        delta_limit_r    <= delta_limit_nxt;
        awaiting_first_r <= awaiting_first_nxt;
        lost_hold_r      <= lost_hold_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_r  <= in_req_type;
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (proc_go && has_result) begin
      out_status_r <= status_nxt;
      out_lost_r   <= lost_hold_nxt;
      out_cnt_r    <= res_cnt_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_check_status     = out_status_r;
  assign out_lost_count       = out_lost_r;
  assign out_received_counter = out_cnt_r;

  `E2ERC_ASSERT(a_stall_needs_item, in_stall |-> s1_valid_r, "stall without a held item")
  `E2ERC_ASSERT(a_idx_bound, byte_idx_r <= IDX_MAX, "frame position beyond maximum")
  `E2ERC_ASSERT(a_lost_hold_quiet, !proc_go |=> $stable(lost_hold_r), "lost count moved while idle")
  `E2ERC_ASSERT(a_first_once, !awaiting_first_r |=> !awaiting_first_r, "first frame flag set again")

endmodule
